>>> rtl/core/drop_pulse_qualifier_with_jitter_macros.svh
// Assertion macros shared by the drop pulse qualifier checker.
// No dependencies; taken in by `include where assertions are written.
`ifndef DROP_PULSE_QUALIFIER_WITH_JITTER_MACROS_SVH
`define DROP_PULSE_QUALIFIER_WITH_JITTER_MACROS_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define DPQJ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dpqj: next-cycle property failed");

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define DPQJ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dpqj: same-cycle property failed");

// Checked in every cycle, reset included.
`define DPQJ_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("dpqj: reset property failed");

`endif

>>> rtl/core/dpqj_pkg.sv
// Shared types, widths and codes of the drop pulse qualifier.
// No dependencies; used by every module of the block.
package dpqj_pkg;

    localparam int MAX_LOGGED_DROPS = 100;
    localparam int LOG_W      = 7;
    localparam int TIME_W     = 32;
    localparam int CFG_W      = 16;
    localparam int IV_W       = 20;
    localparam int IVSQ_W     = 2 * IV_W;
    localparam int SUM_W      = 27;
    localparam int SQ_W       = 47;
    localparam int A_W        = SQ_W + LOG_W;
    localparam int B_W        = 2 * SUM_W;
    localparam int ROOT_SHIFT = 24;
    localparam int REM_W      = A_W + ROOT_SHIFT;
    localparam int CV_W       = 16;
    localparam int B2_SHIFT   = 2 * (CV_W - 1);
    localparam int QS_W       = B_W + B2_SHIFT + 4;
    localparam int BIT_W      = $clog2(CV_W);

    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int S_TDATA_W   = 40;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 64;
    localparam int M_PAYLOAD_W = 1 + TIME_W + LOG_W + CV_W + 1;

    localparam logic [LOG_W-1:0] MAX_LOG           = LOG_W'(MAX_LOGGED_DROPS);
    localparam logic [LOG_W-1:0] MIN_LOG_JITTER    = LOG_W'(3);
    localparam logic [LOG_W-1:0] MIN_LOG_INTERVAL  = LOG_W'(2);
    localparam logic [IV_W-1:0]  IV_MAX            = {IV_W{1'b1}};
    localparam logic [CFG_W-1:0] MIN_WIDTH_RESET   = CFG_W'(4);
    localparam logic [CFG_W-1:0] REFRACT_RESET     = CFG_W'(50);

    localparam logic REG_MIN_WIDTH = 1'b0;
    localparam logic REG_REFRACT   = 1'b1;

    typedef enum logic [1:0] {
        OP_EDGE  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_QUERY = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_EXEC   = 8'b0000_0010,
        ST_SQUARE = 8'b0000_0100,
        ST_ACCUM  = 8'b0000_1000,
        ST_MUL    = 8'b0001_0000,
        ST_DIFF   = 8'b0010_0000,
        ST_ROOT   = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic [CFG_W-1:0] min_width;
        logic [CFG_W-1:0] refract;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic square;
        logic accum;
        logic mul;
        logic diff;
        logic root_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_accum;
        logic need_jitter;
        logic root_last;
    } dp_stat_t;

endpackage

>>> rtl/core/dpqj_regs.sv
// APB register file holding the pulse width and refractory settings.
// Depends on dpqj_pkg.
module dpqj_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dpqj_pkg::PADDR_W-1:0]   paddr,
    input  logic [dpqj_pkg::PDATA_W-1:0]   pwdata,
    output logic [dpqj_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output dpqj_pkg::cfg_t                 cfg
);

    logic [dpqj_pkg::CFG_W-1:0] min_width_reg, min_width_next;
    logic [dpqj_pkg::CFG_W-1:0] refract_reg, refract_next;
    logic                       wr_en;
    logic                       reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_comb begin
        min_width_next = min_width_reg;
        refract_next   = refract_reg;
        if (wr_en) begin
            if (reg_idx == dpqj_pkg::REG_MIN_WIDTH) begin
                min_width_next = pwdata[dpqj_pkg::CFG_W-1:0];
            end else begin
                refract_next = pwdata[dpqj_pkg::CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_width_reg <= dpqj_pkg::MIN_WIDTH_RESET;
            refract_reg   <= dpqj_pkg::REFRACT_RESET;
        end else begin
            min_width_reg <= min_width_next;
            refract_reg   <= refract_next;
        end
    end

    assign prdata = (reg_idx == dpqj_pkg::REG_MIN_WIDTH)
                  ? dpqj_pkg::PDATA_W'(min_width_reg)
                  : dpqj_pkg::PDATA_W'(refract_reg);

    assign cfg.min_width = min_width_reg;
    assign cfg.refract   = refract_reg;

endmodule

>>> rtl/core/dpqj_ctrl.sv
// Sequencing state machine of the drop pulse qualifier.
// Depends on dpqj_pkg; drives the datapath through ctrl_cmd_t.
module dpqj_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  dpqj_pkg::dp_stat_t  stat,
    output dpqj_pkg::ctrl_cmd_t cmd
);

    dpqj_pkg::state_t state_reg, state_next;
    logic             m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            dpqj_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = dpqj_pkg::ST_EXEC;
                end
            end
            dpqj_pkg::ST_EXEC: begin
                cmd.exec = 1'b1;
                priority if (stat.need_accum) begin
                    state_next = dpqj_pkg::ST_SQUARE;
                end else if (stat.need_jitter) begin
                    state_next = dpqj_pkg::ST_MUL;
                end else begin
                    state_next = dpqj_pkg::ST_DONE;
                end
            end
            dpqj_pkg::ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = dpqj_pkg::ST_ACCUM;
            end
            dpqj_pkg::ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = dpqj_pkg::ST_DONE;
            end
            dpqj_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = dpqj_pkg::ST_DIFF;
            end
            dpqj_pkg::ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = dpqj_pkg::ST_ROOT;
            end
            dpqj_pkg::ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (stat.root_last) begin
                    state_next = dpqj_pkg::ST_DONE;
                end
            end
            dpqj_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = dpqj_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dpqj_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        priority if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dpqj_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == dpqj_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

>>> rtl/core/dpqj_dp.sv
// Datapath: pulse qualification, interval statistics, and the bit-serial
// square root and divide for the jitter figure. Depends on dpqj_pkg.
module dpqj_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dpqj_pkg::ctrl_cmd_t                 cmd,
    output dpqj_pkg::dp_stat_t                  stat,
    input  dpqj_pkg::cfg_t                      cfg,
    input  logic [dpqj_pkg::S_TUSER_W-1:0]      in_opcode,
    input  logic                                in_level,
    input  logic [dpqj_pkg::TIME_W-1:0]         in_time,
    output logic [dpqj_pkg::M_PAYLOAD_W-1:0]    out_payload
);

    localparam int TIME_W = dpqj_pkg::TIME_W;
    localparam int LOG_W  = dpqj_pkg::LOG_W;
    localparam int IV_W   = dpqj_pkg::IV_W;
    localparam int SUM_W  = dpqj_pkg::SUM_W;
    localparam int SQ_W   = dpqj_pkg::SQ_W;
    localparam int A_W    = dpqj_pkg::A_W;
    localparam int B_W    = dpqj_pkg::B_W;
    localparam int REM_W  = dpqj_pkg::REM_W;
    localparam int QS_W   = dpqj_pkg::QS_W;
    localparam int CV_W   = dpqj_pkg::CV_W;
    localparam int BIT_W  = dpqj_pkg::BIT_W;

    dpqj_pkg::opcode_t          op_reg;
    logic                       level_reg;
    logic [TIME_W-1:0]          time_reg;

    logic [TIME_W-1:0]          pulse_start_reg, last_drop_reg, last_logged_reg;
    logic [TIME_W-1:0]          drop_cnt_reg;
    logic [LOG_W-1:0]           log_cnt_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [SQ_W-1:0]            sq_reg;

    logic [IV_W-1:0]            iv_reg;
    logic [dpqj_pkg::IVSQ_W-1:0] ivsq_reg;
    logic [A_W-1:0]             a_reg;
    logic [B_W-1:0]             b_reg;
    logic [REM_W-1:0]           rem_reg;
    logic [QS_W-1:0]            b2_reg, qs_reg;
    logic [BIT_W-1:0]           bit_cnt_reg;
    logic [CV_W-1:0]            cv_reg;
    logic                       acc_reg, valid_reg;
    logic [dpqj_pkg::M_PAYLOAD_W-1:0] out_reg;

    logic [TIME_W-1:0]          pulse_width, since_drop, iv_raw;
    logic [IV_W-1:0]            iv_sat;
    logic                       qualify, log_room, log_interval, jit_ok;
    logic [LOG_W-1:0]           n_intervals;
    logic [A_W-1:0]             d_val;
    logic [QS_W-1:0]            trial, qs_acc;
    logic                       fits;

    assign pulse_width  = time_reg - pulse_start_reg;
    assign since_drop   = time_reg - last_drop_reg;
    assign iv_raw       = time_reg - last_logged_reg;
    assign iv_sat       = (iv_raw > TIME_W'(dpqj_pkg::IV_MAX)) ? dpqj_pkg::IV_MAX
                                                               : iv_raw[IV_W-1:0];
    assign qualify      = (op_reg == dpqj_pkg::OP_EDGE) && level_reg
                        && (pulse_width >= TIME_W'(cfg.min_width))
                        && (since_drop > TIME_W'(cfg.refract));
    assign log_room     = log_cnt_reg < dpqj_pkg::MAX_LOG;
    assign log_interval = log_cnt_reg >= dpqj_pkg::MIN_LOG_INTERVAL;
    assign jit_ok       = (op_reg == dpqj_pkg::OP_QUERY)
                        && (log_cnt_reg >= dpqj_pkg::MIN_LOG_JITTER);

    assign stat.need_accum  = qualify && log_room && log_interval;
    assign stat.need_jitter = jit_ok && (sum_reg != '0);
    assign stat.root_last   = (bit_cnt_reg == '0);

    assign n_intervals = log_cnt_reg - dpqj_pkg::MIN_LOG_INTERVAL;
    assign d_val       = (a_reg > b_reg) ? (a_reg - b_reg) : '0;

    assign trial  = qs_reg + b2_reg;
    assign fits   = trial <= QS_W'(rem_reg);
    assign qs_acc = fits ? (qs_reg + {b2_reg[QS_W-2:0], 1'b0}) : qs_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg    <= dpqj_pkg::opcode_t'(in_opcode);
            level_reg <= in_level;
            time_reg  <= in_time;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_start_reg <= '0;
            last_drop_reg   <= '0;
            last_logged_reg <= '0;
            drop_cnt_reg    <= '0;
            log_cnt_reg     <= '0;
            sum_reg         <= '0;
            sq_reg          <= '0;
        end else if (cmd.exec) begin
            unique case (op_reg)
                dpqj_pkg::OP_EDGE: begin
                    if (!level_reg) begin
                        pulse_start_reg <= time_reg;
                    end else if (qualify) begin
                        drop_cnt_reg  <= drop_cnt_reg + TIME_W'(1);
                        last_drop_reg <= time_reg;
                        if (log_room) begin
                            last_logged_reg <= time_reg;
                            log_cnt_reg     <= log_cnt_reg + LOG_W'(1);
                        end
                    end
                end
                dpqj_pkg::OP_CLEAR: begin
                    log_cnt_reg <= '0;
                    sum_reg     <= '0;
                    sq_reg      <= '0;
                end
                dpqj_pkg::OP_QUERY: begin
                end
                dpqj_pkg::OP_NOP: begin
                end
                default: begin
                end
            endcase
        end else if (cmd.accum) begin
            sum_reg <= sum_reg + SUM_W'(iv_reg);
            sq_reg  <= sq_reg + SQ_W'(ivsq_reg);
        end
    end

    // Square root of D * 2^24 compared against q^2 * S^2, one result bit a
    // cycle from the top. qs_reg holds q*S^2 and b2_reg holds S^2, both
    // pre-scaled for the bit under test.
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            iv_reg    <= iv_sat;
            acc_reg   <= qualify;
            valid_reg <= jit_ok;
            cv_reg    <= '0;
        end
        if (cmd.square) begin
            ivsq_reg <= iv_reg * iv_reg;
        end
        if (cmd.mul) begin
            a_reg <= A_W'(n_intervals) * A_W'(sq_reg);
            b_reg <= B_W'(sum_reg) * B_W'(sum_reg);
        end
        if (cmd.diff) begin
            rem_reg     <= {d_val, {dpqj_pkg::ROOT_SHIFT{1'b0}}};
            b2_reg      <= QS_W'(b_reg) << dpqj_pkg::B2_SHIFT;
            qs_reg      <= '0;
            bit_cnt_reg <= BIT_W'(CV_W - 1);
        end
        if (cmd.root_step) begin
            if (fits) begin
                rem_reg <= rem_reg - trial[REM_W-1:0];
            end
            qs_reg      <= qs_acc >> 1;
            b2_reg      <= b2_reg >> 2;
            cv_reg      <= {cv_reg[CV_W-2:0], fits};
            bit_cnt_reg <= bit_cnt_reg - BIT_W'(1);
        end
        if (cmd.load_out) begin
            out_reg <= {valid_reg, cv_reg, log_cnt_reg, drop_cnt_reg, acc_reg};
        end
    end

    assign out_payload = out_reg;

endmodule

>>> rtl/core/drop_pulse_qualifier_with_jitter.sv
// Channel    Dir  Fields (lowest bit first)
// s_ stream  in   tuser: opcode[1:0]; tdata: pin_level, time_ms[32:1]
// m_ stream  out  tdata: drop_accepted, drop_total, logged_drops, jitter_cv, jitter_valid
// APB        in   register 0 min_pulse_width_ms at 0x0, register 1 refractory_ms at 0x4
// An edge event or clear passes from accept through the exec state to done; a
// logged drop that updates the interval sums also passes through square then accumulate.
// A jitter query with at least three logged drops and a nonzero interval sum also runs
// multiply, difference and the 16-step bit-serial root and divide; others skip them.
// A new beat is taken while the previous result waits; a stalled m_ side holds
// the next result in the done state. Reset is synchronous and needs no sweep.
// Top level of the drop pulse qualifier; depends on dpqj_pkg, dpqj_regs,
// dpqj_ctrl and dpqj_dp.
module drop_pulse_qualifier_with_jitter (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // opcode[1:0]
    input  logic [dpqj_pkg::S_TUSER_W-1:0]     s_tuser,
    // pin_level[0], time_ms[32:1], zero pad
    input  logic [dpqj_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // drop_accepted[0], drop_total[32:1], logged_drops[39:33],
    // jitter_cv[55:40], jitter_valid[56], zero pad
    output logic [dpqj_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dpqj_pkg::PADDR_W-1:0]       paddr,
    input  logic [dpqj_pkg::PDATA_W-1:0]       pwdata,
    output logic [dpqj_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    dpqj_pkg::cfg_t                      cfg;
    dpqj_pkg::ctrl_cmd_t                 cmd;
    dpqj_pkg::dp_stat_t                  stat;
    logic [dpqj_pkg::M_PAYLOAD_W-1:0]    payload;

    dpqj_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dpqj_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dpqj_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .cfg         (cfg),
        .in_opcode   (s_tuser),
        .in_level    (s_tdata[0]),
        .in_time     (s_tdata[dpqj_pkg::TIME_W:1]),
        .out_payload (payload)
    );

    assign m_tdata = dpqj_pkg::M_TDATA_W'(payload);

endmodule

>>> rtl/core/dpqj_chk.sv
// Port-level checker for the drop pulse qualifier, bound to the top level.
// Depends on dpqj_pkg and drop_pulse_qualifier_with_jitter_macros.svh.
`include "drop_pulse_qualifier_with_jitter_macros.svh"

module dpqj_chk (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [dpqj_pkg::M_TDATA_W-1:0]     m_tdata
);

    // A stalled result beat keeps its payload.
    `DPQJ_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // One item is worked on at a time, so input is refused right after a beat.
    `DPQJ_ASSERT_NEXT(a_s_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // Reset empties the result register.
    `DPQJ_ASSERT_ALWAYS_NEXT(a_rst_empty, aclk, !aresetn, !m_tvalid)

    // A jitter figure only appears when it is marked valid.
    `DPQJ_ASSERT_NOW(a_cv_gated, aclk, aresetn, m_tvalid && !m_tdata[56], m_tdata[55:40] == '0)

endmodule

bind drop_pulse_qualifier_with_jitter dpqj_chk u_dpqj_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
